@@ sv/dbrr_pkg.sv @@
// Shared types, codes and constants for the round-robin doorbell slot engine.
package dbrr_pkg;

  localparam int SlotsCap      = 64;
  localparam int SlotW         = 6;
  localparam int SlotInW       = 7;
  localparam int CfgW          = 7;
  localparam int ValueW        = 64;
  localparam int NumGrp        = 8;
  localparam int GrpW          = 8;
  localparam int GrpIdxW       = 3;
  localparam int MaxSlotsDef   = 64;
  localparam int BlockBytesDef = 64;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_SERVICE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_NONE    = 2'd2
  } status_e;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
  } scan_res_t;

endpackage

@@ sv/dbrr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dbrr_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dbrr_scan.sv @@
// Two-stage round-robin finder over the nonzero doorbell mask.
module dbrr_scan (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [dbrr_pkg::SlotsCap-1:0]       elig_i,
  input  logic [dbrr_pkg::SlotW-1:0]          first_i,
  output logic                                done_o,
  output dbrr_pkg::scan_res_t                 res_o
);

  logic [dbrr_pkg::NumGrp-1:0]                         hi_any_d, lo_any_d;
  logic [dbrr_pkg::NumGrp-1:0][dbrr_pkg::GrpIdxW-1:0]  hi_pos_d, lo_pos_d;
  logic [dbrr_pkg::NumGrp-1:0]                         hi_any_q, lo_any_q;
  logic [dbrr_pkg::NumGrp-1:0][dbrr_pkg::GrpIdxW-1:0]  hi_pos_q, lo_pos_q;
  logic                                                v1_q, done_q;
  logic [dbrr_pkg::GrpIdxW-1:0]                        hg, lg;
  dbrr_pkg::scan_res_t                                 res_d, res_q;

  always_comb begin
    hi_any_d = '0;
    lo_any_d = '0;
    hi_pos_d = '0;
    lo_pos_d = '0;
    for (int g = 0; g < dbrr_pkg::NumGrp; g++) begin
      for (int j = dbrr_pkg::GrpW - 1; j >= 0; j--) begin
        if (elig_i[g*dbrr_pkg::GrpW + j]) begin
          lo_any_d[g] = 1'b1;
          lo_pos_d[g] = dbrr_pkg::GrpIdxW'(j);
          if (dbrr_pkg::SlotW'(g*dbrr_pkg::GrpW + j) >= first_i) begin
            hi_any_d[g] = 1'b1;
            hi_pos_d[g] = dbrr_pkg::GrpIdxW'(j);
          end
        end
      end
    end
  end

  always_comb begin
    hg = '0;
    lg = '0;
    for (int g = dbrr_pkg::NumGrp - 1; g >= 0; g--) begin
      if (hi_any_q[g]) begin
        hg = dbrr_pkg::GrpIdxW'(g);
      end
      if (lo_any_q[g]) begin
        lg = dbrr_pkg::GrpIdxW'(g);
      end
    end
    res_d.found = (|hi_any_q) | (|lo_any_q);
    if (|hi_any_q) begin
      res_d.slot = {hg, hi_pos_q[hg]};
    end else if (|lo_any_q) begin
      res_d.slot = {lg, lo_pos_q[lg]};
    end else begin
      res_d.slot = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_any_q <= hi_any_d;
      lo_any_q <= lo_any_d;
      hi_pos_q <= hi_pos_d;
      lo_pos_q <= lo_pos_d;
    end
    if (v1_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ sv/dbrr_mul.sv @@
// Saturating byte count: block count times block size in low-half, high-half and sum phases.
module dbrr_mul #(
  parameter int BLOCK_BYTES = dbrr_pkg::BlockBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dbrr_pkg::ValueW-1:0] blocks_i,
  output logic                        done_o,
  output logic [dbrr_pkg::ValueW-1:0] bytes_o
);

  localparam int BbW  = $clog2(BLOCK_BYTES + 1);
  localparam int PpW  = 32 + BbW;
  localparam int SumW = 65 + BbW;
  localparam logic [BbW-1:0] Bb = BbW'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    PH_LO  = 3'b001,
    PH_HI  = 3'b010,
    PH_SUM = 3'b100
  } phase_e;

  logic                        busy_q, done_q;
  phase_e                      ph_q;
  logic [dbrr_pkg::ValueW-1:0] blocks_q, bytes_q;
  logic [PpW-1:0]              pp_lo_q, pp_hi_q, prod;
  logic [31:0]                 mult_a;
  logic [SumW-1:0]             sum;

  assign mult_a = (ph_q == PH_LO) ? blocks_q[31:0] : blocks_q[63:32];
  assign prod   = PpW'(mult_a) * PpW'(Bb);
  assign sum    = (SumW'(pp_hi_q) << 32) + SumW'(pp_lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= PH_LO;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= PH_LO;
      end else if (busy_q) begin
        unique case (ph_q)
          PH_LO:   ph_q <= PH_HI;
          PH_HI:   ph_q <= PH_SUM;
          default: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      blocks_q <= blocks_i;
    end else if (busy_q) begin
      unique case (ph_q)
        PH_LO:   pp_lo_q <= prod;
        PH_HI:   pp_hi_q <= prod;
        default: bytes_q <= (|sum[SumW-1:64]) ? '1 : sum[63:0];
      endcase
    end
  end

  assign done_o  = done_q;
  assign bytes_o = bytes_q;

endmodule

@@ sv/doorbell_round_robin_slot_engine.sv @@
// Top level of the round-robin doorbell slot engine.
//
// Items arrive on in_valid_i/in_stall_o and results leave on out_valid_o/out_stall_i;
// an item moves at a clock edge with valid high and stall low. Every item yields
// exactly one result. Doorbell writes and reads access the RAM in S_ACC and then
// go to S_OUT, where the result waits for the output register.
// A dropped access or an unknown command skips S_ACC and goes straight to S_OUT.
// A service request runs the two-stage round-robin finder over the nonzero mask;
// if a slot is found it then does one RAM read of the served slot and runs the
// byte-count multiplier, else it goes straight to S_OUT.
// One item is in flight at a time, so RAM read-modify-write never overlaps.
// The output register holds a finished item while out_stall_i is high; the next
// item is accepted and worked on meanwhile, then waits for the output register.
// cfg_we_i writes the slot count (clamped to 1..MAX_SLOTS) and moves the scan
// pointer to the last active slot; write it only while the block is idle.
// Reset clears all doorbells through per-slot nonzero flags, sets the slot count
// to MAX_SLOTS and is usable on the first cycle after release.
module doorbell_round_robin_slot_engine #(
  parameter int MAX_SLOTS   = dbrr_pkg::MaxSlotsDef,
  parameter int BLOCK_BYTES = dbrr_pkg::BlockBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dbrr_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [dbrr_pkg::SlotInW-1:0]  slot_i,
  input  logic                          doorbell_kind_i,
  input  logic [dbrr_pkg::ValueW-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [dbrr_pkg::SlotW-1:0]    result_slot_o,
  output logic [dbrr_pkg::ValueW-1:0]   read_value_o,
  output logic [dbrr_pkg::ValueW-1:0]   byte_count_o,
  output logic                          overwrote_pending_o
);

  localparam int IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [dbrr_pkg::CfgW-1:0] MaxSl = dbrr_pkg::CfgW'(MAX_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,
    S_SCAN = 6'b000100,
    S_SRD  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [dbrr_pkg::CfgW-1:0]       eff_q, cfg_eff, cfg_last7;
  logic [dbrr_pkg::SlotW-1:0]      last_q, first, srv_q;
  logic [dbrr_pkg::SlotW:0]        nxt7;
  logic [MAX_SLOTS-1:0]            full_nz_q, done_nz_q;
  logic [dbrr_pkg::SlotsCap-1:0]   elig;

  dbrr_pkg::cmd_e                  cmd_in, cmd_q;
  logic                            kind_q;
  logic [IdxW-1:0]                 slot_q, srv_idx, full_raddr;
  logic [dbrr_pkg::ValueW-1:0]     value_q, full_rdata, done_rdata, rd_masked;

  logic [1:0]                      res_status_q, out_status_q;
  logic [dbrr_pkg::SlotW-1:0]      res_slot_q, out_slot_q;
  logic [dbrr_pkg::ValueW-1:0]     res_read_q, out_read_q, res_bytes_q, out_bytes_q;
  logic                            res_over_q, out_over_q, out_valid_q;

  logic                            in_accept, drop_now, out_free, acc_write;
  logic                            scan_start, scan_done, mul_done, full_re;
  dbrr_pkg::scan_res_t             scan_res;
  logic [dbrr_pkg::ValueW-1:0]     mul_bytes;

  assign cmd_in     = dbrr_pkg::cmd_e'(cmd_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign acc_write  = (state_q == S_ACC) && (cmd_q == dbrr_pkg::CMD_WRITE);
  assign srv_idx    = srv_q[IdxW-1:0];

  always_comb begin
    unique case (cmd_in) inside
      dbrr_pkg::CMD_WRITE,
      dbrr_pkg::CMD_READ:    drop_now = ({1'b0, slot_i} >= {1'b0, eff_q});
      dbrr_pkg::CMD_SERVICE: drop_now = 1'b0;
      default:               drop_now = 1'b1;
    endcase
  end

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_eff = dbrr_pkg::CfgW'(1);
    end else if (cfg_wdata_i > MaxSl) begin
      cfg_eff = MaxSl;
    end else begin
      cfg_eff = cfg_wdata_i;
    end
    cfg_last7 = cfg_eff - dbrr_pkg::CfgW'(1);
  end

  always_comb begin
    elig = '0;
    for (int b = 0; b < MAX_SLOTS; b++) begin
      elig[b] = full_nz_q[b] && (dbrr_pkg::CfgW'(b) < eff_q);
    end
    nxt7  = {1'b0, last_q} + 7'd1;
    first = (nxt7 == eff_q) ? '0 : nxt7[dbrr_pkg::SlotW-1:0];
  end

  assign scan_start = in_accept && (cmd_in == dbrr_pkg::CMD_SERVICE);

  dbrr_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .elig_i  (elig),
    .first_i (first),
    .done_o  (scan_done),
    .res_o   (scan_res)
  );

  assign full_re    = in_accept || ((state_q == S_SCAN) && scan_done);
  assign full_raddr = (state_q == S_SCAN) ? scan_res.slot[IdxW-1:0] : slot_i[IdxW-1:0];

  dbrr_ram #(
    .Width (dbrr_pkg::ValueW),
    .Depth (MAX_SLOTS)
  ) u_full_ram (
    .clk_i   (clk_i),
    .we_i    (acc_write && !kind_q),
    .waddr_i (slot_q),
    .wdata_i (value_q),
    .re_i    (full_re),
    .raddr_i (full_raddr),
    .rdata_o (full_rdata)
  );

  dbrr_ram #(
    .Width (dbrr_pkg::ValueW),
    .Depth (MAX_SLOTS)
  ) u_done_ram (
    .clk_i   (clk_i),
    .we_i    (acc_write && kind_q),
    .waddr_i (slot_q),
    .wdata_i (value_q),
    .re_i    (in_accept),
    .raddr_i (slot_i[IdxW-1:0]),
    .rdata_o (done_rdata)
  );

  dbrr_mul #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_SRD),
    .blocks_i (full_rdata),
    .done_o   (mul_done),
    .bytes_o  (mul_bytes)
  );

  always_comb begin
    if (kind_q) begin
      rd_masked = done_nz_q[slot_q] ? done_rdata : '0;
    end else begin
      rd_masked = full_nz_q[slot_q] ? full_rdata : '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (drop_now) begin
            state_d = S_OUT;
          end else if (cmd_in == dbrr_pkg::CMD_SERVICE) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_ACC;
          end
        end
      end
      S_ACC:  state_d = S_OUT;
      S_SCAN: begin
        if (scan_done) begin
          state_d = scan_res.found ? S_SRD : S_OUT;
        end
      end
      S_SRD:  state_d = S_MUL;
      S_MUL: begin
        if (mul_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eff_q       <= MaxSl;
      last_q      <= dbrr_pkg::SlotW'(MAX_SLOTS - 1);
      full_nz_q   <= '0;
      done_nz_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        eff_q  <= cfg_eff;
        last_q <= cfg_last7[dbrr_pkg::SlotW-1:0];
      end
      if (acc_write) begin
        if (kind_q) begin
          done_nz_q[slot_q] <= |value_q;
        end else begin
          full_nz_q[slot_q] <= |value_q;
        end
      end
      if (state_q == S_SRD) begin
        full_nz_q[srv_idx] <= 1'b0;
        last_q             <= srv_q;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q        <= cmd_in;
      kind_q       <= doorbell_kind_i;
      slot_q       <= slot_i[IdxW-1:0];
      value_q      <= value_i;
      res_status_q <= drop_now ? dbrr_pkg::ST_DROPPED : dbrr_pkg::ST_OK;
      res_slot_q   <= '0;
      res_read_q   <= '0;
      res_bytes_q  <= '0;
      res_over_q   <= 1'b0;
    end
    if (state_q == S_ACC) begin
      if (cmd_q == dbrr_pkg::CMD_WRITE) begin
        res_over_q <= kind_q ? done_nz_q[slot_q] : full_nz_q[slot_q];
      end else begin
        res_read_q <= rd_masked;
      end
    end
    if ((state_q == S_SCAN) && scan_done) begin
      if (scan_res.found) begin
        srv_q <= scan_res.slot;
      end else begin
        res_status_q <= dbrr_pkg::ST_NONE;
      end
    end
    if (state_q == S_SRD) begin
      res_slot_q <= srv_q;
      res_read_q <= full_rdata;
    end
    if ((state_q == S_MUL) && mul_done) begin
      res_bytes_q <= mul_bytes;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_read_q   <= res_read_q;
      out_bytes_q  <= res_bytes_q;
      out_over_q   <= res_over_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign result_slot_o       = out_slot_q;
  assign read_value_o        = out_read_q;
  assign byte_count_o        = out_bytes_q;
  assign overwrote_pending_o = out_over_q;

  a_last_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, last_q} < eff_q))
    else $error("scan pointer beyond slot count");

  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> (state_q == S_SCAN))
    else $error("finder result outside scan state");

  a_served_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRD) |-> full_nz_q[srv_idx])
    else $error("served slot has no pending doorbell");

  a_served_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRD) |=> !full_nz_q[srv_idx])
    else $error("served doorbell not cleared");

  a_none_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == dbrr_pkg::ST_NONE)) |->
      ((result_slot_o == '0) && (read_value_o == '0) && (byte_count_o == '0)))
    else $error("empty service result carries data");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the round-robin doorbell slot engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam logic       KindFull   = 1'b0;
  localparam logic       KindDone   = 1'b1;
  localparam int         PhaseItems = 115;

  typedef struct {
    logic [1:0]                   cmd;
    logic [dbrr_pkg::SlotInW-1:0] slot;
    logic                         kind;
    logic [dbrr_pkg::ValueW-1:0]  value;
  } doorbell_req_t;

  typedef struct {
    dbrr_pkg::status_e           status;
    logic [dbrr_pkg::SlotW-1:0]  slot;
    logic [dbrr_pkg::ValueW-1:0] value;
    logic [dbrr_pkg::ValueW-1:0] bytes;
    logic                        overwrote;
  } doorbell_resp_t;

  logic                         clk_i               = 1'b0;
  logic                         rst_ni              = 1'b0;
  logic                         cfg_we_i            = 1'b0;
  logic [dbrr_pkg::CfgW-1:0]    cfg_wdata_i         = '0;
  logic                         in_valid_i          = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   cmd_i               = dbrr_pkg::CMD_WRITE;
  logic [dbrr_pkg::SlotInW-1:0] slot_i              = '0;
  logic                         doorbell_kind_i     = KindFull;
  logic [dbrr_pkg::ValueW-1:0]  value_i             = '0;
  logic                         out_valid_o;
  logic                         out_stall_i         = 1'b0;
  logic [1:0]                   status_o;
  logic [dbrr_pkg::SlotW-1:0]   result_slot_o;
  logic [dbrr_pkg::ValueW-1:0]  read_value_o;
  logic [dbrr_pkg::ValueW-1:0]  byte_count_o;
  logic                         overwrote_pending_o;

  doorbell_round_robin_slot_engine #(
    .MAX_SLOTS  (dbrr_pkg::MaxSlotsDef),
    .BLOCK_BYTES(dbrr_pkg::BlockBytesDef)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .slot_i             (slot_i),
    .doorbell_kind_i    (doorbell_kind_i),
    .value_i            (value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .result_slot_o      (result_slot_o),
    .read_value_o       (read_value_o),
    .byte_count_o       (byte_count_o),
    .overwrote_pending_o(overwrote_pending_o)
  );

  logic [dbrr_pkg::ValueW-1:0] full_bank [dbrr_pkg::SlotsCap];
  logic [dbrr_pkg::ValueW-1:0] done_bank [dbrr_pkg::SlotsCap];
  int unsigned                 slot_count_reg;
  int unsigned                 last_served;

  doorbell_req_t  pending_reqs[$];
  doorbell_resp_t expected_resps[$];

  bit calm;
  bit in_taken;
  int gap_left;
  int out_hold;
  int errors;
  int items_accepted;
  int resps_checked;
  int served;
  int saturated;
  int dropped;
  int empty_scans;
  int phases;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned active_slots();
    if (slot_count_reg < 1) return 1;
    if (slot_count_reg > dbrr_pkg::MaxSlotsDef) return dbrr_pkg::MaxSlotsDef;
    return slot_count_reg;
  endfunction

  function automatic logic [dbrr_pkg::ValueW-1:0] sat_bytes(
      logic [dbrr_pkg::ValueW-1:0] blocks);
    logic [2*dbrr_pkg::ValueW-1:0] prod;
    prod = {{dbrr_pkg::ValueW{1'b0}}, blocks} * dbrr_pkg::BlockBytesDef;
    if (prod[2*dbrr_pkg::ValueW-1:dbrr_pkg::ValueW] != '0) return '1;
    return prod[dbrr_pkg::ValueW-1:0];
  endfunction

  function automatic void predict_doorbell_op(logic [1:0] cmd,
                                              logic [dbrr_pkg::SlotInW-1:0] slot,
                                              logic kind,
                                              logic [dbrr_pkg::ValueW-1:0] value);
    doorbell_resp_t r;
    int unsigned    n;
    int unsigned    idx;
    n = active_slots();
    r = '{status: dbrr_pkg::ST_OK, slot: '0, value: '0, bytes: '0, overwrote: 1'b0};
    case (cmd) inside
      dbrr_pkg::CMD_WRITE, dbrr_pkg::CMD_READ: begin
        if (slot >= n) begin
          r.status = dbrr_pkg::ST_DROPPED;
          dropped++;
        end else if (cmd == dbrr_pkg::CMD_WRITE) begin
          if (kind == KindDone) begin
            r.overwrote = (done_bank[slot] != '0);
            done_bank[slot] = value;
          end else begin
            r.overwrote = (full_bank[slot] != '0);
            full_bank[slot] = value;
          end
        end else begin
          r.value = (kind == KindDone) ? done_bank[slot] : full_bank[slot];
        end
      end
      dbrr_pkg::CMD_SERVICE: begin
        r.status = dbrr_pkg::ST_NONE;
        idx = (last_served % n + 1) % n;
        for (int k = 0; k < n; k++) begin
          if (r.status == dbrr_pkg::ST_NONE && full_bank[idx] != '0) begin
            r.status = dbrr_pkg::ST_OK;
            r.slot   = idx[dbrr_pkg::SlotW-1:0];
            r.value  = full_bank[idx];
            r.bytes  = sat_bytes(full_bank[idx]);
            full_bank[idx] = '0;
            last_served = idx;
          end
          idx = (idx + 1) % n;
        end
        if (r.status == dbrr_pkg::ST_NONE) empty_scans++;
        else begin
          served++;
          if (r.bytes == '1) saturated++;
        end
      end
      default: begin
        r.status = dbrr_pkg::ST_DROPPED;
        dropped++;
      end
    endcase
    expected_resps.push_back(r);
  endfunction

  // drive the next item once the current one is taken
  always @(negedge clk_i) begin
    doorbell_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        cmd_i           <= req.cmd;
        slot_i          <= req.slot;
        doorbell_kind_i <= req.kind;
        value_i         <= req.value;
        in_valid_i      <= 1'b1;
        gap_left = calm ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    doorbell_resp_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected result: status %0d slot %0d", status_o, result_slot_o);
          errors++;
        end else begin
          exp_r = expected_resps.pop_front();
          resps_checked++;
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            errors++;
          end
          if (result_slot_o !== exp_r.slot) begin
            $error("result_slot: expected %0d, got %0d", exp_r.slot, result_slot_o);
            errors++;
          end
          if (read_value_o !== exp_r.value) begin
            $error("read_value: expected %h, got %h", exp_r.value, read_value_o);
            errors++;
          end
          if (byte_count_o !== exp_r.bytes) begin
            $error("byte_count: expected %h, got %h", exp_r.bytes, byte_count_o);
            errors++;
          end
          if (overwrote_pending_o !== exp_r.overwrote) begin
            $error("overwrote_pending: expected %0d, got %0d", exp_r.overwrote,
                   overwrote_pending_o);
            errors++;
          end
        end
        out_hold = calm ? 0 : $urandom_range(0, 15);
      end
      if (in_valid_i && !in_stall_o) begin
        predict_doorbell_op(cmd_i, slot_i, doorbell_kind_i, value_i);
        in_taken = 1'b1;
        items_accepted++;
      end
    end
  end

  task automatic queue_req(logic [1:0] cmd, logic [dbrr_pkg::SlotInW-1:0] slot, logic kind,
                           logic [dbrr_pkg::ValueW-1:0] value);
    pending_reqs.push_back('{cmd: cmd, slot: slot, kind: kind, value: value});
  endtask

  function automatic logic [dbrr_pkg::ValueW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 45) return dbrr_pkg::ValueW'($urandom_range(1, 1000));
    if (sel < 60) return (dbrr_pkg::ValueW'(1) << 58) - dbrr_pkg::ValueW'($urandom_range(0, 3))
                         + dbrr_pkg::ValueW'($urandom_range(0, 3));
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random_req();
    int unsigned                  n;
    int unsigned                  sel;
    logic [dbrr_pkg::SlotInW-1:0] slot;
    n = active_slots();
    sel = $urandom_range(0, 99);
    slot = ($urandom_range(0, 99) < 85) ? dbrr_pkg::SlotInW'($urandom_range(0, n - 1))
                                        : dbrr_pkg::SlotInW'($urandom_range(0, 127));
    if (sel < 42)      queue_req(dbrr_pkg::CMD_WRITE, slot, KindFull, pick_value());
    else if (sel < 72) queue_req(dbrr_pkg::CMD_SERVICE, dbrr_pkg::SlotInW'($urandom),
                                 1'($urandom), {$urandom, $urandom});
    else if (sel < 82) queue_req(dbrr_pkg::CMD_READ, slot, KindFull, {$urandom, $urandom});
    else if (sel < 87) queue_req(dbrr_pkg::CMD_WRITE, slot, KindDone, pick_value());
    else if (sel < 92) queue_req(dbrr_pkg::CMD_READ, slot, KindDone, {$urandom, $urandom});
    else if (sel < 97) queue_req(sel[0] ? dbrr_pkg::CMD_READ : dbrr_pkg::CMD_WRITE,
                                 dbrr_pkg::SlotInW'($urandom_range(n, 127)), 1'($urandom),
                                 pick_value());
    else               queue_req(CmdUnknown, dbrr_pkg::SlotInW'($urandom), 1'($urandom),
                                 {$urandom, $urandom});
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_resps.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_slot_count(logic [dbrr_pkg::CfgW-1:0] count);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    slot_count_reg = count;
    last_served = active_slots() - 1;
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    logic [dbrr_pkg::CfgW-1:0] settings [10];
    settings = '{7'd127, 7'd17, 7'd64, 7'd1, 7'd0, 7'd2,
                 dbrr_pkg::CfgW'($urandom_range(0, 127)),
                 7'd64, 7'd33, dbrr_pkg::CfgW'($urandom_range(0, 127))};
    for (int i = 0; i < dbrr_pkg::SlotsCap; i++) begin
      full_bank[i] = '0;
      done_bank[i] = '0;
    end
    slot_count_reg = dbrr_pkg::MaxSlotsDef;
    last_served = active_slots() - 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: empty scan, extremes, overwrite, saturation, dropped accesses
    queue_req(dbrr_pkg::CMD_SERVICE, '0, KindFull, '0);
    queue_req(dbrr_pkg::CMD_READ, 7'd63, KindFull, '1);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd0, KindFull, '1);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd0, KindFull, 64'd1);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd63, KindFull, 64'h0400_0000_0000_0000);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd5, KindFull, 64'h03ff_ffff_ffff_ffff);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd5, KindDone, '1);
    queue_req(dbrr_pkg::CMD_READ, 7'd5, KindDone, '0);
    queue_req(dbrr_pkg::CMD_READ, 7'd0, KindFull, '0);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd64, KindFull, 64'd9);
    queue_req(dbrr_pkg::CMD_READ, 7'd127, KindDone, '0);
    queue_req(CmdUnknown, 7'd0, KindFull, '1);
    queue_req(dbrr_pkg::CMD_SERVICE, '1, KindDone, '1);
    queue_req(dbrr_pkg::CMD_SERVICE, '0, KindFull, '0);
    queue_req(dbrr_pkg::CMD_SERVICE, '0, KindFull, '0);
    queue_req(dbrr_pkg::CMD_SERVICE, '0, KindFull, '0);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd10, KindFull, '1);
    queue_req(dbrr_pkg::CMD_SERVICE, '0, KindFull, '0);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd5, KindDone, '0);
    queue_req(dbrr_pkg::CMD_WRITE, 7'd63, KindFull, 64'h8000_0000_0000_0000);
    queue_req(dbrr_pkg::CMD_SERVICE, '0, KindFull, '0);
    drain();

    for (int p = 0; p <= 10; p++) begin
      if (p > 0) write_slot_count(settings[p-1]);
      calm = (p % 4 == 3);
      @(posedge clk_i);
      for (int k = 0; k < PhaseItems; k++) queue_random_req();
      drain();
      phases++;
    end

    $display("covered %0d items and %0d checked results over %0d slot-count settings",
             items_accepted, resps_checked, phases);
    $display("served %0d doorbells (%0d saturated), %0d empty scans, %0d accesses dropped",
             served, saturated, empty_scans, dropped);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
